>>> sv/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg: shared definitions for the unique value set store
// Capacity, derived widths, request actions, result status codes and the
// control bundle that the top level hands to each storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

  // Number of entries the store can hold.
  localparam int unsigned CAPACITY = 16;

  // Width of one stored value.
  localparam int unsigned VAL_W = 32;

  // Width of the entry count, which must be able to hold CAPACITY itself.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Request actions.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Per-cell control from the top level.
  typedef struct packed {
    logic valid;   // cell holds a live entry
    logic wr;      // load the request value into this cell
    logic rm;      // a remove request is being applied this cycle
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/uvs_cell.sv
// ----------------------------------------------------------------------------
// uvs_cell: one storage cell of the set store
// Holds one value, compares it against the request value, passes the
// "match seen so far" flag up the chain and, during a remove, takes the
// value of its upper neighbor once the match lies at or below it.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_cell (
  input  wire                                clk_i,
  input  wire uvs_pkg::cell_ctrl_t           ctrl_i,
  input  wire logic [uvs_pkg::VAL_W-1:0]     req_value_i,
  input  wire logic [uvs_pkg::VAL_W-1:0]     next_value_i,
  input  wire logic                          hit_i,
  output logic      [uvs_pkg::VAL_W-1:0]     value_o,
  output logic                               hit_o
);
  import uvs_pkg::*;

  logic [VAL_W-1:0] value_q;
  logic [VAL_W-1:0] value_d;
  logic             match;

  // A live entry equal to the request value is a match.
  assign match   = ctrl_i.valid && (value_q == req_value_i);
  assign hit_o   = hit_i | match;
  assign value_o = value_q;

  // Load on insert; on remove every cell from the match upward moves down.
  always_comb begin
    value_d = value_q;
    if (ctrl_i.wr) begin
      value_d = req_value_i;
    end else if (ctrl_i.rm && hit_o) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

>>> sv/unique_value_set_store_top.sv
// ----------------------------------------------------------------------------
// unique_value_set_store_top: set of distinct 32-bit values in insert order
// A chain of storage cells searches all entries in parallel, appends new
// values at the fill point and closes gaps on remove by shifting down.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_ready_o with action_i (0 insert if
//   absent, 1 remove first match) and value_i. Each request yields exactly
//   one result on out_valid_o/out_ready_i carrying status_o and count_o,
//   the number of entries held after the request.
//   The result is registered at the edge that accepts the request. Throughput
//   is one request per cycle while out_ready_i stays high; the compare, the match
//   chain through the cells and the shift all complete in the accepting cycle.
//   While a result waits, in_ready_o follows out_ready_i, so a new request
//   is taken in the same cycle the waiting result leaves. If the receiver
//   stalls, the result holds and no further request is accepted.
//   Reset clears the entry count and the output valid; the store is empty
//   and ready at once, with no clearing pass. Capacity is CAPACITY entries;
//   an insert of an absent value into a full store drops it and reports full.
// ----------------------------------------------------------------------------
`default_nettype none

module unique_value_set_store_top (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire                           action_i,
  input  wire logic signed [31:0]       value_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [2:0]                    status_o,
  output logic [4:0]                    count_o
);
  import uvs_pkg::*;

  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic              out_valid_q;
  status_e           status_q;
  status_e           status_d;
  logic [CNT_W-1:0]  res_count_q;

  logic              accept;
  logic              found;
  logic              full;
  logic              do_insert;
  logic              do_remove;
  logic [VAL_W-1:0]  req_value;

  cell_ctrl_t        ctrl   [CAPACITY];
  logic [VAL_W-1:0]  cell_val [CAPACITY];
  logic [CAPACITY:0] hit;

  // Handshake: take a request when the output register is free or emptying.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign req_value  = value_i;

  assign found     = hit[CAPACITY];
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign do_insert = accept && (action_i == ACT_INSERT) && !found && !full;
  assign do_remove = accept && (action_i == ACT_REMOVE) && found;

  // Cell chain: the match flag ripples upward, values shift downward.
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] next_val;

    if (i == CAPACITY - 1) begin : g_top
      assign next_val = cell_val[i];
    end else begin : g_mid
      assign next_val = cell_val[i+1];
    end

    assign ctrl[i].valid = (CNT_W'(i) < count_q);
    assign ctrl[i].wr    = do_insert && (count_q == CNT_W'(i));
    assign ctrl[i].rm    = do_remove;

    uvs_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[i]),
      .req_value_i  (req_value),
      .next_value_i (next_val),
      .hit_i        (hit[i]),
      .value_o      (cell_val[i]),
      .hit_o        (hit[i+1])
    );
  end

  // Result status and next count.
  always_comb begin
    count_d = count_q;
    if (action_i == ACT_INSERT) begin
      if (found) begin
        status_d = ST_PRESENT;
      end else if (full) begin
        status_d = ST_FULL;
      end else begin
        status_d = ST_INSERTED;
        count_d  = count_q + CNT_W'(1);
      end
    end else begin
      if (found) begin
        status_d = ST_REMOVED;
        count_d  = count_q - CNT_W'(1);
      end else begin
        status_d = ST_NOT_FOUND;
      end
    end
  end

  // Control state: entry count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      res_count_q <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign count_o     = 5'(res_count_q);

endmodule

`default_nettype wire

>>> sv/uvs_checker.sv
// ----------------------------------------------------------------------------
// uvs_checker: port-level assertions for the unique value set store
// Watches the top level's ports only and is attached through a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_checker (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              in_valid_i,
  input wire              in_ready_i,
  input wire              action_i,
  input wire              out_valid_i,
  input wire              out_ready_i,
  input wire [2:0]        status_i,
  input wire [4:0]        count_i
);
  import uvs_pkg::*;

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(count_i))
    else $error("result changed while stalled");

  // A remove request answers removed or not found in the next cycle.
  a_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (action_i == ACT_REMOVE) |=>
      out_valid_i && (status_i == ST_REMOVED || status_i == ST_NOT_FOUND))
    else $error("remove request gave a wrong status");

  // The count never passes the capacity.
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (count_i <= 5'(CAPACITY)))
    else $error("count above capacity");

  // Full is reported only with the store at capacity.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_FULL) |-> (count_i == 5'(CAPACITY)))
    else $error("full reported below capacity");

endmodule

bind unique_value_set_store_top uvs_checker u_uvs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .action_i    (action_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_i    (status_o),
  .count_i     (count_o)
);

`default_nettype wire
